>>> rtl/core/mns_pkg.sv
// ----------------------------------------------------------------------------
// mns_pkg
// Shared types, constants and the note-value conversion for the melody
// note sequencer.
// ----------------------------------------------------------------------------
package mns_pkg;

   localparam int MNS_MAX_NOTES = 64;

   localparam int FREQ_W    = 16;
   localparam int LEN_W     = 16;
   localparam int TIME_W    = 32;
   localparam int POS_W     = 6;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHOLE_NOTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_EN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_GAP   = 2'd3;

   localparam logic [LEN_W-1:0] WHOLE_NOTE_RST = 16'd2000;
   localparam logic [LEN_W-1:0] GAP_RST        = 16'd10;
   localparam logic [LEN_W-1:0] LOOP_GAP_RST   = 16'd1000;

   // item kinds
   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_POLL = 1'b1;

   localparam logic [FREQ_W-1:0] REST_LIMIT = 16'd31;
   localparam logic [LEN_W-1:0]  CODE_LIMIT = 16'd10;

   typedef struct packed {
      logic [LEN_W-1:0] whole_note_ms;
      logic [LEN_W-1:0] gap_ms;
      logic             loop_enable;
      logic [LEN_W-1:0] loop_gap_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EMIT
   } seq_state_type;

   // Note-value code to milliseconds; products wrap at 16 bits before the shift.
   function automatic logic [LEN_W-1:0] code_to_ms(input logic [3:0]       code,
                                                   input logic [LEN_W-1:0] whole);
      logic [LEN_W-1:0] w2;
      logic [LEN_W-1:0] w3;
      logic [LEN_W-1:0] w5;
      logic [LEN_W-1:0] w7;
      logic [LEN_W-1:0] res;
      w2 = whole << 1;
      w3 = whole + (whole << 1);
      w5 = whole + (whole << 2);
      w7 = (whole << 3) - whole;
      case (code)
         4'd0: res = w2;
         4'd1: res = whole;
         4'd2: res = w7 >> 3;
         4'd3: res = w3 >> 2;
         4'd4: res = w5 >> 3;
         4'd5: res = whole >> 1;
         4'd6: res = w3 >> 3;
         4'd7: res = whole >> 2;
         4'd8: res = whole >> 3;
         4'd9: res = whole >> 4;
         default: res = {{(LEN_W-4){1'b0}}, code};
      endcase
      return res;
   endfunction

endpackage

>>> rtl/core/mns_ram.sv
// ----------------------------------------------------------------------------
// mns_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/mns_len_conv.sv
// ----------------------------------------------------------------------------
// mns_len_conv
// Turns an incoming note length into milliseconds (codes below ten are
// note values scaled from the whole-note length).
// ----------------------------------------------------------------------------
module mns_len_conv
   import mns_pkg::*;
(
   input  logic [LEN_W-1:0] note_length,
   input  logic [LEN_W-1:0] whole_note_ms,
   output logic [LEN_W-1:0] length_ms
);

   always_comb begin
      if (note_length < CODE_LIMIT) begin
         length_ms = code_to_ms(note_length[3:0], whole_note_ms);
      end else begin
         length_ms = note_length;
      end
   end

endmodule

>>> rtl/core/mns_seq.sv
// ----------------------------------------------------------------------------
// mns_seq
// Sequencer: note count, play position and finish time, table access and
// the result register.
// ----------------------------------------------------------------------------
module mns_seq
   import mns_pkg::*;
#(
   parameter int MAX_NOTES = MNS_MAX_NOTES,
   parameter int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [FREQ_W-1:0]   req_freq,
   input  logic [LEN_W-1:0]    req_len_ms,
   input  logic [TIME_W-1:0]   req_now,
   output logic                mem_we,
   output logic [IDX_W-1:0]    mem_waddr,
   output logic [FREQ_W+LEN_W-1:0] mem_wdata,
   output logic                mem_re,
   output logic [IDX_W-1:0]    mem_raddr,
   input  logic [FREQ_W+LEN_W-1:0] mem_rdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [FREQ_W-1:0]   rsp_freq,
   output logic [LEN_W-1:0]    rsp_tone_ms,
   output logic [POS_W-1:0]    rsp_pos
);

   localparam int CNT_W = $clog2(MAX_NOTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NOTES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  play_ff, play_in;
   logic [TIME_W-1:0] finish_ff, finish_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              out_valid_ff, out_valid_in;
   logic [FREQ_W-1:0] out_freq_ff, out_freq_in;
   logic [LEN_W-1:0]  out_tone_ff, out_tone_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;

   logic [FREQ_W-1:0] rd_freq;
   logic [LEN_W-1:0]  rd_len;
   logic [LEN_W-1:0]  tone_ms;
   logic [CNT_W-1:0]  play_next;
   logic              out_free;
   logic              load_out;

   assign rd_freq   = mem_rdata[FREQ_W-1:0];
   assign rd_len    = mem_rdata[FREQ_W+LEN_W-1:FREQ_W];
   assign tone_ms   = (rd_len > cfg.gap_ms) ? (rd_len - cfg.gap_ms) : '0;
   assign play_next = play_ff + CNT_ONE;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign req_ready = (state_ff == SEQ_IDLE);
   assign mem_waddr = total_ff[IDX_W-1:0];
   assign mem_wdata = {req_len_ms, req_freq};
   assign mem_raddr = play_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      play_in   = play_ff;
      finish_in = finish_ff;
      now_in    = now_ff;
      slot_in   = slot_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_ADD) begin
                  if (total_ff < CNT_MAX) begin
                     mem_we   = 1'b1;
                     total_in = total_ff + CNT_ONE;
                  end
               end else if (play_ff < total_ff && req_now >= finish_ff) begin
                  mem_re   = 1'b1;
                  now_in   = req_now;
                  slot_in  = play_ff[IDX_W-1:0];
                  state_in = SEQ_READ;
               end
            end
         end
         SEQ_READ: begin
            if (cfg.loop_enable && play_next >= total_ff) begin
               play_in   = '0;
               finish_in = now_ff + TIME_W'(rd_len) + TIME_W'(cfg.loop_gap_ms);
            end else begin
               play_in   = play_next;
               finish_in = now_ff + TIME_W'(rd_len);
            end
            if (rd_freq < REST_LIMIT) begin
               state_in = SEQ_IDLE;
            end else if (out_free) begin
               load_out = 1'b1;
               state_in = SEQ_IDLE;
            end else begin
               state_in = SEQ_EMIT;
            end
         end
         SEQ_EMIT: begin
            // read data is held, no read since the access
            if (out_free) begin
               load_out = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff && !rsp_ready;
      out_freq_in  = out_freq_ff;
      out_tone_in  = out_tone_ff;
      out_pos_in   = out_pos_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_freq_in  = rd_freq;
         out_tone_in  = tone_ms;
         out_pos_in   = POS_W'(slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         total_ff     <= '0;
         play_ff      <= '0;
         finish_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         play_ff      <= play_in;
         finish_ff    <= finish_in;
         out_valid_ff <= out_valid_in;
      end
      now_ff      <= now_in;
      slot_ff     <= slot_in;
      out_freq_ff <= out_freq_in;
      out_tone_ff <= out_tone_in;
      out_pos_ff  <= out_pos_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_freq    = out_freq_ff;
   assign rsp_tone_ms = out_tone_ff;
   assign rsp_pos     = out_pos_ff;

`ifndef NO_ASSERTIONS
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("table written and read in the same cycle");

   a_play_in_range: assert property (@(posedge clock) disable iff (reset)
      play_ff <= total_ff)
      else $error("play position beyond note count");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_MAX)
      else $error("note count beyond table depth");

   a_read_follows_access: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_READ) |-> $past(mem_re))
      else $error("read state without a table access");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("result register overwritten while waiting");
`endif

endmodule

>>> rtl/core/melody_note_sequencer_core.sv
// ----------------------------------------------------------------------------
// melody_note_sequencer_core
// Note table sequencer: stores notes, steps through them on time polls and
// issues one tone start per sounded note.
// ----------------------------------------------------------------------------
// Use:
//   req_ channel carries an item: tuser = mode (0 add, 1 poll), tdata holds
//   note_frequency, note_length and now_ms. An add stores the note at the end
//   of the table (ignored when full). A poll whose now_ms has reached the
//   finish time steps to the next note; a sounded note yields one rsp_ item.
//   rsp_ tdata holds tone_frequency, tone_length_ms and note_position.
//   csr_ port: write csr_wdata to register csr_index when csr_we is high,
//   only while the block is idle.
// Steps:
//   An add writes the table from idle. A poll that steps issues the table
//   read; the read state sees the registered RAM data, updates the finish
//   time and loads the result register, or waits in the emit state until it
//   frees, as the RAM has one read port. A load shows on rsp_ the cycle after.
// Reset: note count, play position and finish time clear, registers take
//   their defaults; the table itself is not cleared (no clearing pass).
// Stall: a result waits in the output register while rsp_tready is low and
//   adds or polls are still taken; a second result waits inside the core,
//   holding off req_tready, until the register frees.
// ----------------------------------------------------------------------------
module melody_note_sequencer_core
   import mns_pkg::*;
#(
   parameter int MAX_NOTES = MNS_MAX_NOTES
) (
   input  logic                 clock,
   input  logic                 reset,
   // request items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // note_frequency, note_length, now_ms
   input  logic [0:0]           req_tuser,   // mode
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // tone_frequency, tone_length_ms,
                                             // note_position, zero pad
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
   localparam int ROW_W = FREQ_W + LEN_W;

   // configuration registers
   logic [LEN_W-1:0] whole_note_ff, whole_note_in;
   logic [LEN_W-1:0] gap_ff, gap_in;
   logic             loop_en_ff, loop_en_in;
   logic [LEN_W-1:0] loop_gap_ff, loop_gap_in;
   cfg_type          cfg;

   always_comb begin
      whole_note_in = whole_note_ff;
      gap_in        = gap_ff;
      loop_en_in    = loop_en_ff;
      loop_gap_in   = loop_gap_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WHOLE_NOTE: whole_note_in = csr_wdata;
            CSR_GAP:        gap_in        = csr_wdata;
            CSR_LOOP_EN:    loop_en_in    = csr_wdata[0];
            CSR_LOOP_GAP:   loop_gap_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_note_ff <= WHOLE_NOTE_RST;
         gap_ff        <= GAP_RST;
         loop_en_ff    <= 1'b0;
         loop_gap_ff   <= LOOP_GAP_RST;
      end else begin
         whole_note_ff <= whole_note_in;
         gap_ff        <= gap_in;
         loop_en_ff    <= loop_en_in;
         loop_gap_ff   <= loop_gap_in;
      end
   end

   assign cfg.whole_note_ms = whole_note_ff;
   assign cfg.gap_ms        = gap_ff;
   assign cfg.loop_enable   = loop_en_ff;
   assign cfg.loop_gap_ms   = loop_gap_ff;

   // request fields
   logic [FREQ_W-1:0] req_freq;
   logic [LEN_W-1:0]  req_length;
   logic [TIME_W-1:0] req_now;
   logic [LEN_W-1:0]  req_len_ms;

   assign req_freq   = req_tdata[15:0];
   assign req_length = req_tdata[31:16];
   assign req_now    = req_tdata[63:32];

   mns_len_conv u_len_conv (
      .note_length   (req_length),
      .whole_note_ms (whole_note_ff),
      .length_ms     (req_len_ms)
   );

   // note table, row = {length, frequency}
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [ROW_W-1:0] mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   logic [ROW_W-1:0] mem_rdata;

   mns_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_NOTES),
      .ADDR_W(IDX_W)
   ) u_note_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   logic [FREQ_W-1:0] rsp_freq;
   logic [LEN_W-1:0]  rsp_tone_ms;
   logic [POS_W-1:0]  rsp_pos;

   mns_seq #(
      .MAX_NOTES(MAX_NOTES),
      .IDX_W    (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser[0]),
      .req_freq   (req_freq),
      .req_len_ms (req_len_ms),
      .req_now    (req_now),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_freq   (rsp_freq),
      .rsp_tone_ms(rsp_tone_ms),
      .rsp_pos    (rsp_pos)
   );

   assign rsp_tdata = {2'b00, rsp_pos, rsp_tone_ms, rsp_freq};

endmodule

>>> test/melody_note_sequencer_core_checker.sv
// ----------------------------------------------------------------------------
// melody_note_sequencer_core_checker
// Watches the request, result and register ports of the note sequencer,
// keeps its own copy of the note table and timing state, predicts every tone
// start and compares the results against it in order.
// ----------------------------------------------------------------------------
module melody_note_sequencer_core_checker
   import mns_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [63:0]          req_tdata,   // note_frequency, note_length, now_ms
   input  logic [0:0]           req_tuser,   // mode
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [39:0]          rsp_tdata,   // tone_frequency, tone_length_ms,
                                             // note_position, zero pad
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   tones_due,
   output int                   tones_checked,
   output int                   adds_taken,
   output int                   polls_taken
);

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
      logic [FREQ_W-1:0] freq;
   } tone_start_type;

   logic [FREQ_W-1:0] freq_store [MNS_MAX_NOTES];
   logic [LEN_W-1:0]  len_store  [MNS_MAX_NOTES];
   int unsigned       notes_held;
   int unsigned       cursor;
   logic [TIME_W-1:0] finish_at;
   cfg_type           regs;
   tone_start_type    tone_starts_due [$];

   // note-value code: 16-bit product, then a power-of-two divide
   function automatic logic [LEN_W-1:0] note_value_ms(input logic [3:0]       code,
                                                      input logic [LEN_W-1:0] whole);
      logic [LEN_W-1:0] prod;
      int               shift;
      prod  = whole;
      shift = 0;
      case (code)
         4'd0: prod = LEN_W'(whole * 2);
         4'd2: begin prod = LEN_W'(whole * 7); shift = 3; end
         4'd3: begin prod = LEN_W'(whole * 3); shift = 2; end
         4'd4: begin prod = LEN_W'(whole * 5); shift = 3; end
         4'd5: shift = 1;
         4'd6: begin prod = LEN_W'(whole * 3); shift = 3; end
         4'd7: shift = 2;
         4'd8: shift = 3;
         4'd9: shift = 4;
         default: ;
      endcase
      return prod >> shift;
   endfunction

   task automatic store_note(input logic [FREQ_W-1:0] freq, input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] ms;
      ms = (len < CODE_LIMIT) ? note_value_ms(len[3:0], regs.whole_note_ms) : len;
      if (notes_held < MNS_MAX_NOTES) begin
         freq_store[notes_held] = freq;
         len_store[notes_held]  = ms;
         notes_held++;
      end
   endtask

   task automatic step_melody(input logic [TIME_W-1:0] now);
      tone_start_type    due;
      logic [FREQ_W-1:0] freq;
      logic [LEN_W-1:0]  len;
      int unsigned       pos;
      if (cursor >= notes_held || now < finish_at)
         return;
      pos       = cursor;
      freq      = freq_store[pos];
      len       = len_store[pos];
      cursor    = pos + 1;
      finish_at = now + len;
      if (regs.loop_enable && cursor >= notes_held) begin
         cursor    = 0;
         finish_at = finish_at + regs.loop_gap_ms;
      end
      if (freq >= REST_LIMIT) begin
         due.freq = freq;
         due.len  = (len > regs.gap_ms) ? len - regs.gap_ms : '0;
         due.pos  = pos[POS_W-1:0];
         tone_starts_due.push_back(due);
      end
   endtask

   always @(posedge clock) begin : watch
      tone_start_type got;
      tone_start_type want;
      if (reset) begin
         notes_held     = 0;
         cursor         = 0;
         finish_at      = '0;
         regs.whole_note_ms = WHOLE_NOTE_RST;
         regs.gap_ms        = GAP_RST;
         regs.loop_enable   = 1'b0;
         regs.loop_gap_ms   = LOOP_GAP_RST;
         tone_starts_due.delete();
         mismatch_count = 0;
         tones_checked  = 0;
         adds_taken     = 0;
         polls_taken    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WHOLE_NOTE: regs.whole_note_ms = csr_wdata;
               CSR_GAP:        regs.gap_ms        = csr_wdata;
               CSR_LOOP_EN:    regs.loop_enable   = csr_wdata[0];
               CSR_LOOP_GAP:   regs.loop_gap_ms   = csr_wdata;
               default: ;
            endcase
         end
         // retire the oldest expectation before a new one can join
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[POS_W+LEN_W+FREQ_W-1:0];
            if (tone_starts_due.size() == 0) begin
               $error("unexpected tone start: freq %0d len %0d pos %0d",
                      got.freq, got.len, got.pos);
               mismatch_count++;
            end else begin
               want = tone_starts_due.pop_front();
               tones_checked++;
               if (got.freq !== want.freq) begin
                  $error("tone_frequency: expected %0d, actual %0d", want.freq, got.freq);
                  mismatch_count++;
               end
               if (got.len !== want.len) begin
                  $error("tone_length_ms: expected %0d, actual %0d", want.len, got.len);
                  mismatch_count++;
               end
               if (got.pos !== want.pos) begin
                  $error("note_position: expected %0d, actual %0d", want.pos, got.pos);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == MODE_ADD) begin
               adds_taken++;
               store_note(req_tdata[15:0], req_tdata[31:16]);
            end else begin
               polls_taken++;
               step_melody(req_tdata[63:32]);
            end
         end
      end
      tones_due = tone_starts_due.size();
   end

endmodule

>>> test/melody_note_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// melody_note_sequencer_core_tb
// Drives note adds and time polls into the sequencer under a series of
// register settings, with random gaps and result back-pressure; the checker
// beside the block predicts and compares every tone start.
// ----------------------------------------------------------------------------
module melody_note_sequencer_core_tb;
   import mns_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [63:0]          req_tdata;   // note_frequency, note_length, now_ms
   logic [0:0]           req_tuser;   // mode
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [39:0]          rsp_tdata;   // tone_frequency, tone_length_ms,
                                      // note_position, zero pad
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   int mismatch_count;
   int tones_due;
   int tones_checked;
   int adds_taken;
   int polls_taken;

   // stimulus state
   bit          calm;        // a stretch with no idling on either side
   int          adds_sent;   // upper bound on notes held in the table
   logic [31:0] ms_now;      // the millisecond count that polls carry

   melody_note_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   melody_note_sequencer_core_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .tones_due      (tones_due),
      .tones_checked  (tones_checked),
      .adds_taken     (adds_taken),
      .polls_taken    (polls_taken)
   );

   always #6 clock = ~clock;

   function automatic int pause_draw();
      if (calm)
         return 0;
      return $urandom_range(0, 16);
   endfunction

   // One item on req_; returns at the edge that accepts it. Ready is looked
   // at on the falling edge, where nothing is moving.
   task automatic offer_request(input logic mode, input logic [15:0] freq,
                                input logic [15:0] len, input logic [31:0] now);
      int pause;
      pause = pause_draw();
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {now, len, freq};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // all four registers back to back; only called with the block idle
   task automatic program_settings(input logic [15:0] whole, input logic [15:0] gap,
                                   input logic loop_on, input logic [15:0] loop_gap);
      logic [14:0] junk;
      junk = 15'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_WHOLE_NOTE;
      csr_wdata <= whole;
      @(posedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      // upper bits are don't-care for the loop flag
      csr_index <= CSR_LOOP_EN;
      csr_wdata <= {junk, loop_on};
      @(posedge clock);
      csr_index <= CSR_LOOP_GAP;
      csr_wdata <= loop_gap;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // wait for every predicted tone, then let a rest poll drain from the core
   task automatic settle();
      do @(negedge clock); while (tones_due != 0);
      repeat (8) @(posedge clock);
   endtask

   // Mostly polls with a rising time base, a share of adds. While looping
   // is off the table is never filled: a played-out full table cannot wrap
   // later, so the run would go quiet for good.
   task automatic issue_random_item(input bit loop_on);
      int          pick;
      logic [15:0] freq;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 12 && (loop_on || adds_sent < MNS_MAX_NOTES - 4)) begin
         pick = $urandom_range(0, 9);
         if (pick < 2)
            freq = 16'($urandom_range(0, REST_LIMIT - 1));
         else
            freq = 16'($urandom_range(REST_LIMIT, 65535));
         pick = $urandom_range(0, 9);
         if (pick < 4)
            len = 16'($urandom_range(0, CODE_LIMIT - 1));
         else if (pick < 8)
            len = 16'($urandom_range(CODE_LIMIT, 600));
         else
            len = 16'($urandom_range(0, 65535));
         adds_sent++;
         offer_request(MODE_ADD, freq, len, $urandom);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            ms_now = ms_now + $urandom_range(0, 600);
         else if (pick < 85)
            ms_now = ms_now + $urandom_range(0, 70000);
         else if (pick >= 97)
            ms_now = '1;   // top of the count: reaches any finish, next sum wraps
         offer_request(MODE_POLL, 16'($urandom), 16'($urandom), ms_now);
      end
   endtask

   // result side: a fresh stall before each item
   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pause_draw();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
      end
   end

   initial begin : watchdog
      #4000000;
      $display("melody_note_sequencer_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] whole;
      logic [15:0] gap;
      logic [15:0] loop_gap;
      bit          loop_on;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = MODE_ADD;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_WHOLE_NOTE;
      csr_wdata  = '0;
      calm       = 1'b0;
      adds_sent  = 0;
      ms_now     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset register values (whole 2000, gap 10, no loop) ---
      // poll on an empty table: nothing left to play
      offer_request(MODE_POLL, 16'hFFFF, 16'hFFFF, 32'd0);
      // every note-value code, then plain lengths at the bottom and top
      offer_request(MODE_ADD, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
      offer_request(MODE_ADD, 16'd31,   16'd1, 32'd0);
      offer_request(MODE_ADD, 16'd30,   16'd2, 32'd0);   // highest rest
      offer_request(MODE_ADD, 16'd0,    16'd3, 32'd0);
      offer_request(MODE_ADD, 16'd440,  16'd4, 32'd0);
      offer_request(MODE_ADD, 16'd1000, 16'd5, 32'd0);
      offer_request(MODE_ADD, 16'h8000, 16'd6, 32'd0);
      offer_request(MODE_ADD, 16'd523,  16'd7, 32'd0);
      offer_request(MODE_ADD, 16'd12345, 16'd8, 32'd0);
      offer_request(MODE_ADD, 16'd880,  16'd9, 32'd0);
      offer_request(MODE_ADD, 16'd262,  16'd10, 32'd0);  // equals the gap: tone of 0
      offer_request(MODE_ADD, 16'd700,  16'hFFFF, 32'd0);
      adds_sent = 12;
      // finish time starts at 0, so a poll at 0 has already reached it
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'd0);
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'd3999);        // one short of finish
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'd4000);        // exactly on it
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'hFFFF_FFFF);   // finish sum wraps
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'd1748);        // rest not yet over
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'd1749);
      offer_request(MODE_POLL, 16'd0, 16'd0, 32'd2000);
      req_tvalid <= 1'b0;
      ms_now = 32'd2000;

      // --- random phases, each under its own register setting ---
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         case (phase)
            0: begin whole = 16'hFFFF; gap = 16'h0000; loop_on = 0; loop_gap = 16'hFFFF; end
            1: begin whole = 16'h0000; gap = 16'hFFFF; loop_on = 0; loop_gap = 16'h0000; end
            2: begin
               whole    = 16'($urandom);
               gap      = 16'($urandom_range(0, 200));
               loop_on  = 1;
               loop_gap = 16'($urandom_range(0, 3000));
            end
            3: begin whole = 16'hFFFF; gap = 16'h0000; loop_on = 1; loop_gap = 16'h0000; end
            4: begin
               whole    = 16'($urandom);
               gap      = 16'($urandom);
               loop_on  = 1;
               loop_gap = 16'hFFFF;
            end
            default: begin
               whole    = 16'($urandom);
               gap      = 16'($urandom_range(0, 600));
               loop_on  = 1;
               loop_gap = 16'($urandom);
            end
         endcase
         program_settings(whole, gap, loop_on, loop_gap);
         for (int n = 0; n < 205; n++) begin
            if (n % 40 == 0)
               calm = ($urandom_range(0, 3) == 0);
            issue_random_item(loop_on);
         end
         req_tvalid <= 1'b0;
      end

      // drain
      do @(negedge clock); while (tones_due != 0);
      repeat (20) @(posedge clock);
      $display("covered %0d note adds and %0d time polls over seven register settings,",
               adds_taken, polls_taken);
      $display("with %0d tone starts checked against prediction", tones_checked);
      if (mismatch_count == 0)
         $display("melody_note_sequencer_core_tb: PASS");
      else
         $display("melody_note_sequencer_core_tb: FAIL");
      $finish;
   end

endmodule
